// File: hw/rtl/ptlru_pkg.sv
`default_nettype none
package ptlru_pkg;

  localparam int LA_W = 12;
  localparam int PA_W = 10;
  localparam int FAULT_W = 32;
  localparam int STAMP_W = 32;

  localparam int NUM_PAGES_DEF = 32;
  localparam int NUM_FRAMES_DEF = 8;
  localparam int PAGE_BYTES_DEF = 128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic fault;
    logic evict;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic free_avail;
    logic scan_last;
  } status_t;

endpackage
`default_nettype wire

// File: hw/rtl/ptlru_ram.sv
`default_nettype none
module ptlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/ptlru_ctrl.sv
`default_nettype none
module ptlru_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire ptlru_pkg::status_t status,
  output ptlru_pkg::cmd_t         cmd
);

  ptlru_pkg::state_t state;
  ptlru_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptlru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ptlru_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = ptlru_pkg::ST_LOOKUP;
        end
      end
      ptlru_pkg::ST_LOOKUP: begin
        if (status.hit) begin
          cmd.commit = 1'b1;
          state_next = ptlru_pkg::ST_IDLE;
        end else if (status.free_avail) begin
          cmd.commit = 1'b1;
          cmd.fault = 1'b1;
          state_next = ptlru_pkg::ST_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = ptlru_pkg::ST_SCAN;
        end
      end
      ptlru_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          cmd.commit = 1'b1;
          cmd.fault = 1'b1;
          cmd.evict = 1'b1;
          state_next = ptlru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ptlru_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/ptlru_dp.sv
`default_nettype none
module ptlru_dp #(
  parameter int NUM_PAGES = ptlru_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = ptlru_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BYTES = ptlru_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ptlru_pkg::LA_W-1:0]    logical_address,
  input  wire ptlru_pkg::cmd_t               cmd,
  output ptlru_pkg::status_t                 status,
  output logic                               done,
  output logic [ptlru_pkg::PA_W-1:0]         physical_address,
  output logic                               page_fault,
  output logic                               evicted,
  output logic [ptlru_pkg::FAULT_W-1:0]      fault_count
);

  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int STAMP_W = ptlru_pkg::STAMP_W;
  localparam int FAULT_W = ptlru_pkg::FAULT_W;
  localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(NUM_FRAMES - 1);

  logic [ptlru_pkg::LA_W-1:0] addr_shift;
  logic [PAGE_W-1:0]          page_in;
  logic [PAGE_W-1:0]          page_q;
  logic [OFF_W-1:0]           offset_q;

  logic [NUM_PAGES-1:0]       page_valid;
  logic [NUM_FRAMES-1:0]      frame_free;
  logic [STAMP_W-1:0]         frame_last_use [NUM_FRAMES];
  logic [PAGE_W-1:0]          frame_owner [NUM_FRAMES];
  logic [STAMP_W-1:0]         access_counter;
  logic [FAULT_W-1:0]         fault_total;
  logic [FAULT_W-1:0]         fault_total_next;

  logic [FRAME_W-1:0]         ram_rdata;
  logic [FRAME_W-1:0]         free_idx;
  logic [FRAME_W-1:0]         scan_idx;
  logic [FRAME_W-1:0]         best;
  logic [FRAME_W-1:0]         best_sel;
  logic [FRAME_W-1:0]         frame_sel;
  logic [FRAME_W+OFF_W-1:0]   pa_full;
  logic                       ram_we;

  assign addr_shift = logical_address >> OFF_W;
  assign page_in = addr_shift[PAGE_W-1:0];
  assign ram_we = cmd.commit && cmd.fault;

  ptlru_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(NUM_PAGES)
  ) u_page_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(page_q),
    .wdata(frame_sel),
    .raddr(page_in),
    .rdata(ram_rdata)
  );

  // lowest free frame from 1 upward
  always_comb begin
    free_idx = '0;
    for (int f = NUM_FRAMES - 1; f >= 1; f--) begin
      if (frame_free[f]) begin
        free_idx = FRAME_W'(f);
      end
    end
  end

  assign best_sel = (frame_last_use[scan_idx] < frame_last_use[best]) ? scan_idx : best;

  always_comb begin
    if (!cmd.fault) begin
      frame_sel = ram_rdata;
    end else if (!cmd.evict) begin
      frame_sel = free_idx;
    end else begin
      frame_sel = best_sel;
    end
  end

  assign status.hit = page_valid[page_q];
  assign status.free_avail = |frame_free[NUM_FRAMES-1:1];
  assign status.scan_last = (scan_idx == LAST_FRAME);

  assign fault_total_next = (cmd.fault && (fault_total != '1)) ? fault_total + 1'b1
                                                                 : fault_total;
  assign pa_full = {frame_sel, offset_q};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_q <= page_in;
      offset_q <= logical_address[OFF_W-1:0];
    end
    if (cmd.scan_start) begin
      scan_idx <= FRAME_W'(1);
      best <= FRAME_W'(1);
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      best <= best_sel;
    end
    if (ram_we) begin
      frame_owner[frame_sel] <= page_q;
    end
    if (cmd.commit) begin
      physical_address <= ptlru_pkg::PA_W'(pa_full);
      page_fault <= cmd.fault;
      evicted <= cmd.evict;
      fault_count <= fault_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= '0;
      frame_free <= ~NUM_FRAMES'(1);
      frame_last_use <= '{default: '0};
      access_counter <= '0;
      fault_total <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        if (cmd.fault) begin
          // drop the old owner before claiming the frame
          if (cmd.evict) begin
            page_valid[frame_owner[frame_sel]] <= 1'b0;
          end
          page_valid[page_q] <= 1'b1;
        end
        frame_last_use[frame_sel] <= access_counter;
        frame_free[frame_sel] <= 1'b0;
        access_counter <= access_counter + 1'b1;
        fault_total <= fault_total_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/page_translate_lru_core.sv
// A request: IDLE takes start and launches the page-table RAM read, LOOKUP commits on a hit
// or a fault with a free frame, and done is registered from the commit. A fault that evicts
// first passes through SCAN, where the stamp search compares one frame per cycle. A new
// request is taken only in IDLE; busy stays high until commit.
// Reset (rst, synchronous): clears valid bits, frame state, stamps and counters;
// the page-frame RAM is not cleared. Results cannot be stalled.
`default_nettype none
module page_translate_lru_core #(
  parameter int NUM_PAGES = ptlru_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = ptlru_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BYTES = ptlru_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ptlru_pkg::LA_W-1:0]    logical_address,
  output logic                               done,
  output logic [ptlru_pkg::PA_W-1:0]         physical_address,
  output logic                               page_fault,
  output logic                               evicted,
  output logic [ptlru_pkg::FAULT_W-1:0]      fault_count
);

  ptlru_pkg::cmd_t    cmd;
  ptlru_pkg::status_t status;

  ptlru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .status(status),
    .cmd   (cmd)
  );

  ptlru_dp #(
    .NUM_PAGES (NUM_PAGES),
    .NUM_FRAMES(NUM_FRAMES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .logical_address (logical_address),
    .cmd             (cmd),
    .status          (status),
    .done            (done),
    .physical_address(physical_address),
    .page_fault      (page_fault),
    .evicted         (evicted),
    .fault_count     (fault_count)
  );

endmodule
`default_nettype wire

// File: hw/rtl/ptlru_checker.sv
`default_nettype none
module ptlru_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic                          page_fault,
  input wire logic                          evicted,
  input wire logic [ptlru_pkg::FAULT_W-1:0] fault_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("done without a finished request");

  a_busy_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("request finished without result");

  a_evict_needs_fault: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> page_fault)
    else $error("eviction on a hit");

  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    (done && page_fault) |-> (fault_count != '0))
    else $error("fault not counted");

endmodule

bind page_translate_lru_core ptlru_checker u_checker (.*);
`default_nettype wire

// File: bench/tb.sv
`default_nettype none
module tb;

  localparam int LA_W = ptlru_pkg::LA_W;
  localparam int PA_W = ptlru_pkg::PA_W;
  localparam int FAULT_W = ptlru_pkg::FAULT_W;
  localparam int STAMP_W = ptlru_pkg::STAMP_W;
  localparam int PAGES = ptlru_pkg::NUM_PAGES_DEF;
  localparam int FRAMES = ptlru_pkg::NUM_FRAMES_DEF;
  localparam int OFF_W = $clog2(ptlru_pkg::PAGE_BYTES_DEF);
  localparam int PAGE_W = $clog2(ptlru_pkg::NUM_PAGES_DEF);
  localparam int FRAME_W = $clog2(ptlru_pkg::NUM_FRAMES_DEF);
  localparam int REQUESTS = 700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 3 * ptlru_pkg::NUM_FRAMES_DEF + 4;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    logic fault;
    logic evict;
    logic [FAULT_W-1:0] count;
  } xlate_t;

  typedef struct {
    logic [LA_W-1:0] la;
    bit typed;
    xlate_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [LA_W-1:0] logical_address = '0;
  logic busy;
  logic done;
  logic [PA_W-1:0] physical_address;
  logic page_fault;
  logic evicted;
  logic [FAULT_W-1:0] fault_count;

  bit page_valid_m[PAGES];
  bit [FRAME_W-1:0] page_frame_m[PAGES];
  bit frame_free_m[FRAMES];
  bit [STAMP_W-1:0] frame_stamp_m[FRAMES];
  bit [PAGE_W-1:0] frame_owner_m[FRAMES];
  bit [STAMP_W-1:0] access_ctr_m;
  bit [FAULT_W-1:0] fault_ctr_m;

  xlate_t expected_xlate[$];
  xlate_t want;
  xlate_t got;
  xlate_t typed_xlate;
  bit use_typed = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  dir_row_t dir_rows[14] = '{
    '{12'h000, 1'b1, '{10'd128, 1'b1, 1'b0, 32'd1}},
    '{12'hFFF, 1'b1, '{10'd383, 1'b1, 1'b0, 32'd2}},
    '{12'h07F, 1'b1, '{10'd255, 1'b0, 1'b0, 32'd2}},
    '{12'hF80, 1'b1, '{10'd256, 1'b0, 1'b0, 32'd2}},
    '{12'h080, 1'b0, '0},
    '{12'h155, 1'b0, '0},
    '{12'h2AA, 1'b0, '0},
    '{12'h555, 1'b0, '0},
    '{12'hAAA, 1'b0, '0},
    '{12'h300, 1'b0, '0},
    '{12'h000, 1'b0, '0},
    '{12'hFFF, 1'b0, '0},
    '{12'h555, 1'b0, '0},
    '{12'h07F, 1'b0, '0}
  };

  page_translate_lru_core u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .logical_address(logical_address),
    .done(done),
    .physical_address(physical_address),
    .page_fault(page_fault),
    .evicted(evicted),
    .fault_count(fault_count)
  );

  always #5 clk = ~clk;

  function automatic void lru_reset();
    for (int f = 0; f < FRAMES; f++) begin
      frame_free_m[f] = (f != 0);
      frame_stamp_m[f] = '0;
      frame_owner_m[f] = '0;
    end
    for (int p = 0; p < PAGES; p++) begin
      page_valid_m[p] = 1'b0;
      page_frame_m[p] = '0;
    end
    access_ctr_m = '0;
    fault_ctr_m = '0;
  endfunction

  function automatic xlate_t lru_translate(logic [LA_W-1:0] la);
    xlate_t r;
    bit [PAGE_W-1:0] page;
    bit [FRAME_W-1:0] frame;
    int best;
    page = la[OFF_W +: PAGE_W];
    r = '0;
    if (page_valid_m[page]) begin
      frame = page_frame_m[page];
    end else begin
      r.fault = 1'b1;
      if (fault_ctr_m != '1) fault_ctr_m++;
      frame = '0;
      for (int f = FRAMES - 1; f >= 1; f--)
        if (frame_free_m[f]) frame = FRAME_W'(f);
      if (frame == 0) begin
        r.evict = 1'b1;
        best = 1;
        for (int f = 2; f < FRAMES; f++)
          if (frame_stamp_m[f] < frame_stamp_m[best]) best = f;
        frame = FRAME_W'(best);
        page_valid_m[frame_owner_m[frame]] = 1'b0;
      end
      page_frame_m[page] = frame;
      page_valid_m[page] = 1'b1;
      frame_owner_m[frame] = page;
    end
    frame_stamp_m[frame] = access_ctr_m;
    frame_free_m[frame] = 1'b0;
    access_ctr_m++;
    r.pa = PA_W'({frame, la[OFF_W-1:0]});
    r.count = fault_ctr_m;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // call at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(logic [LA_W-1:0] la);
    start = 1'b1;
    logical_address = la;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      start = 1'b0;
      logical_address = LA_W'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (expected_xlate.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        got = '{physical_address, page_fault, evicted, fault_count};
        if (expected_xlate.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_xlate.pop_front();
          if (got.pa !== want.pa) begin
            $error("physical_address: expected %0d, got %0d", want.pa, got.pa);
            mismatches++;
          end
          if (got.fault !== want.fault) begin
            $error("page_fault: expected %0d, got %0d", want.fault, got.fault);
            mismatches++;
          end
          if (got.evict !== want.evict) begin
            $error("evicted: expected %0d, got %0d", want.evict, got.evict);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $error("fault_count: expected %0d, got %0d", want.count, got.count);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        want = lru_translate(logical_address);
        expected_xlate.push_back(use_typed ? typed_xlate : want);
      end
    end
  end

  initial begin
    int sent;
    int hot_n;
    int phase_len;
    bit no_idle;
    bit [PAGE_W-1:0] hot[12];
    bit [PAGE_W-1:0] page;

    lru_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      use_typed = dir_rows[i].typed;
      typed_xlate = dir_rows[i].want;
      send_request(dir_rows[i].la);
      idle(pick_gap());
    end
    use_typed = 1'b0;
    wait_drained();

    sent = 0;
    while (sent < REQUESTS) begin
      hot_n = $urandom_range(3, 12);
      foreach (hot[k]) hot[k] = PAGE_W'($urandom_range(0, PAGES - 1));
      phase_len = $urandom_range(30, 80);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < phase_len && sent < REQUESTS; j++) begin
        if ($urandom_range(0, 99) < 80) page = hot[$urandom_range(0, hot_n - 1)];
        else page = PAGE_W'($urandom_range(0, PAGES - 1));
        send_request({page, OFF_W'($urandom)});
        sent++;
        if (!no_idle) idle(pick_gap());
      end
      wait_drained();
    end

    start = 1'b0;
    while (expected_xlate.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
`default_nettype wire

// File: page_translate_lru_core.f
hw/rtl/ptlru_pkg.sv
hw/rtl/ptlru_ram.sv
hw/rtl/ptlru_ctrl.sv
hw/rtl/ptlru_dp.sv
hw/rtl/page_translate_lru_core.sv
hw/rtl/ptlru_checker.sv
bench/tb.sv
